FILE: src/armg_pkg.sv
// ----------------------------------------------------------------------------
// armg_pkg - shared types and constants for the rotation matrix generator
// Field widths, angle reduction constants, radian scale, CORDIC gain and the
// arctangent table used by the pipeline stages.
// ----------------------------------------------------------------------------
package armg_pkg;

  localparam int ANGLE_W  = 24;
  localparam int AXIS_W   = 2;
  localparam int ELEM_W   = 16;
  localparam int NUM_ELEM = 9;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // Angle reduction: bias to a positive value, then restoring division by a
  // quarter turn (11520 units of 1/128 degree).
  localparam int REM_W     = 25;
  localparam int FRAC_W    = 14;
  localparam int QUAD_W    = 2;
  localparam int DIV_STEPS = 11;
  localparam logic [REM_W-1:0] DEG_QUARTER = 25'd11520;
  localparam logic [REM_W-1:0] ANGLE_BIAS  = 25'd8432640;  // 183 full turns

  // Radian conversion: f * RAD_SCALE, split in two 19-bit halves.
  localparam int HALF_W    = 19;
  localparam int PROD_W    = FRAC_W + HALF_W;
  localparam int SUM_W     = PROD_W + HALF_W;
  localparam int RAD_SHIFT = 20;
  localparam logic [2*HALF_W-1:0] RAD_SCALE = 38'd153520784549;
  localparam logic [HALF_W-1:0] RAD_LO = RAD_SCALE[HALF_W-1:0];
  localparam logic [HALF_W-1:0] RAD_HI = RAD_SCALE[2*HALF_W-1:HALF_W];
  localparam logic [SUM_W-1:0]  RAD_ROUND = SUM_W'(1) << (RAD_SHIFT - 1);

  // CORDIC datapath, Q30 values.
  localparam int Z_W  = 33;
  localparam int XY_W = 34;
  localparam int Q_FRAC = 30;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [QUAD_W-1:0] quad;
  } tag_t;

endpackage

FILE: src/axis_rotation_matrix_gen.sv
// ----------------------------------------------------------------------------
// axis_rotation_matrix_gen - elementary 3D rotation matrix from an angle
// Fully pipelined sine/cosine (CORDIC) with angle reduction and matrix build.
// ----------------------------------------------------------------------------
// Stages from input transfer to result: 12 reduction, 2 radian,
// CORDIC_STAGES rotation and 2 output stages.
// Throughput: one transfer per cycle; every stage holds its item while the
// next one is full, so bubbles are filled even when the output stalls.
// Reset: rst clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module axis_rotation_matrix_gen #(
  parameter int CORDIC_STAGES = armg_pkg::CORDIC_STAGES_DEF,
  parameter int OUT_FRAC_BITS = armg_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [armg_pkg::ANGLE_W-1:0] angle_deg,
  input  logic        [armg_pkg::AXIS_W-1:0]  axis,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_0_0,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_1_0,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_2_0,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_0_1,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_1_1,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_2_1,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_0_2,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_1_2,
  output logic signed [armg_pkg::ELEM_W-1:0]  elem_2_2
);
  import armg_pkg::*;

  // reduce -> rad
  logic              red_valid, red_ready;
  logic [FRAC_W-1:0] red_frac;
  tag_t              red_tag;

  // rad -> cordic
  logic              rad_valid, rad_ready;
  logic signed [Z_W-1:0] rad_z;
  tag_t              rad_tag;

  // cordic -> matrix
  logic              cor_valid, cor_ready;
  logic signed [XY_W-1:0] cor_x, cor_y;
  tag_t              cor_tag;

  logic [ELEM_W-1:0] elem [NUM_ELEM];

  // Split the angle into quadrant and in-quadrant remainder. The bias keeps
  // the dividend positive so the remainder is the true modulo.
  armg_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .angle_deg (angle_deg),
    .axis      (axis),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .frac      (red_frac),
    .tag       (red_tag)
  );

  // Convert the remainder to a Q2.30 angle in radians.
  armg_rad u_rad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .frac      (red_frac),
    .tag_in    (red_tag),
    .out_valid (rad_valid),
    .out_ready (rad_ready),
    .z         (rad_z),
    .tag_out   (rad_tag)
  );

  // First-quadrant cosine and sine.
  armg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rad_valid),
    .in_ready  (rad_ready),
    .z         (rad_z),
    .tag_in    (rad_tag),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .x_out     (cor_x),
    .y_out     (cor_y),
    .tag_out   (cor_tag)
  );

  // Round, clamp, apply the quadrant and build the matrix; the last stage is
  // the output register seen on the result channel.
  armg_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .x_in      (cor_x),
    .y_in      (cor_y),
    .tag_in    (cor_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .elem      (elem)
  );

  // Column-major order: element index = second * 3 + first.
  assign elem_0_0 = signed'(elem[0]);
  assign elem_1_0 = signed'(elem[1]);
  assign elem_2_0 = signed'(elem[2]);
  assign elem_0_1 = signed'(elem[3]);
  assign elem_1_1 = signed'(elem[4]);
  assign elem_2_1 = signed'(elem[5]);
  assign elem_0_2 = signed'(elem[6]);
  assign elem_1_2 = signed'(elem[7]);
  assign elem_2_2 = signed'(elem[8]);

  // Input back-pressure only when the whole pipe is full and the result
  // channel is stalled.
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline can advance");

endmodule

FILE: src/armg_reduce.sv
// ----------------------------------------------------------------------------
// armg_reduce - angle reduction pipeline
// Biases the angle positive and splits it into quadrant and remainder with a
// restoring division by a quarter turn, one quotient bit per stage.
// ----------------------------------------------------------------------------
module armg_reduce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [armg_pkg::ANGLE_W-1:0] angle_deg,
  input  logic        [armg_pkg::AXIS_W-1:0]  axis,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [armg_pkg::FRAC_W-1:0]  frac,
  output armg_pkg::tag_t                      tag
);
  import armg_pkg::*;

  localparam int NS = DIV_STEPS + 1;

  logic             vld [NS];
  logic             rdy [NS+1];
  logic [REM_W-1:0] rem [NS];
  tag_t             tg  [NS];

  assign rdy[NS] = out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  // bias stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem[0] <= {angle_deg[ANGLE_W-1], angle_deg} + ANGLE_BIAS;
      tg[0]  <= '{axis: axis, quad: '0};
    end
  end

  // one compare and subtract per stage, largest divisor first
  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = DIV_STEPS - s;
    localparam logic [REM_W-1:0] DIVK = DEG_QUARTER << K;

    logic             ge;
    logic [REM_W-1:0] rem_next;
    tag_t             tag_next;

    always_comb begin
      ge            = rem[s-1] >= DIVK;
      rem_next      = ge ? rem[s-1] - DIVK : rem[s-1];
      tag_next      = tg[s-1];
      tag_next.quad = tg[s-1].quad | (QUAD_W'(ge) << K);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld[s-1]) begin
        rem[s] <= rem_next;
        tg[s]  <= tag_next;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];
  assign frac      = rem[NS-1][FRAC_W-1:0];
  assign tag       = tg[NS-1];

  a_rem_below_quarter: assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] |-> rem[NS-1] < DEG_QUARTER)
    else $error("reduced angle not below a quarter turn");

endmodule

FILE: src/armg_rad.sv
// ----------------------------------------------------------------------------
// armg_rad - degrees to radians
// Multiplies the quarter-turn remainder by the radian scale in two partial
// products and rounds the sum to a Q2.30 angle.
// ----------------------------------------------------------------------------
module armg_rad (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [armg_pkg::FRAC_W-1:0] frac,
  input  armg_pkg::tag_t                     tag_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [armg_pkg::Z_W-1:0]    z,
  output armg_pkg::tag_t                     tag_out
);
  import armg_pkg::*;

  logic              vld0, vld1;
  logic              rdy0, rdy1;
  logic [PROD_W-1:0] p_hi, p_lo;
  tag_t              tg0, tg1;
  logic [SUM_W-1:0]  sum;

  assign rdy1 = !vld1 || out_ready;
  assign rdy0 = !vld0 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else begin
      if (rdy0) vld0 <= in_valid;
      if (rdy1) vld1 <= vld0;
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      p_hi <= PROD_W'(frac) * PROD_W'(RAD_HI);
      p_lo <= PROD_W'(frac) * PROD_W'(RAD_LO);
      tg0  <= tag_in;
    end
  end

  // combine and round half up
  assign sum = {p_hi, {HALF_W{1'b0}}} + SUM_W'(p_lo) + RAD_ROUND;

  always_ff @(posedge clk) begin
    if (rdy1 && vld0) begin
      z   <= signed'({1'b0, sum[SUM_W-1:RAD_SHIFT]});
      tg1 <= tg0;
    end
  end

  assign in_ready  = rdy0;
  assign out_valid = vld1;
  assign tag_out   = tg1;

endmodule

FILE: src/armg_cordic.sv
// ----------------------------------------------------------------------------
// armg_cordic - rotation-mode CORDIC
// One micro-rotation per stage; x and y start at the gain constant and zero
// and converge to cosine and sine of the input angle in Q30.
// ----------------------------------------------------------------------------
module armg_cordic #(
  parameter int STAGES = armg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [armg_pkg::Z_W-1:0]  z,
  input  armg_pkg::tag_t                   tag_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [armg_pkg::XY_W-1:0] x_out,
  output logic signed [armg_pkg::XY_W-1:0] y_out,
  output armg_pkg::tag_t                   tag_out
);
  import armg_pkg::*;

  logic                   vld [STAGES];
  logic                   rdy [STAGES+1];
  logic signed [XY_W-1:0] x   [STAGES];
  logic signed [XY_W-1:0] y   [STAGES];
  logic signed [Z_W-1:0]  zr  [STAGES-1];
  tag_t                   tg  [STAGES];

  assign rdy[STAGES] = out_ready;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN = signed'(Z_W'(ATAN_Q30[i]));

    logic signed [XY_W-1:0] xi, yi;
    logic signed [Z_W-1:0]  zi;
    tag_t                   ti;
    logic                   vi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z;
      assign ti = tag_in;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign zi = zr[i-1];
      assign ti = tg[i-1];
      assign vi = vld[i-1];
    end

    assign rdy[i] = !vld[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= vi;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (rdy[i] && vi) begin
        if (!zi[Z_W-1]) begin
          x[i] <= xi - (yi >>> i);
          y[i] <= yi + (xi >>> i);
        end else begin
          x[i] <= xi + (yi >>> i);
          y[i] <= yi - (xi >>> i);
        end
        tg[i] <= ti;
      end
    end

    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (rdy[i] && vi) begin
          zr[i] <= zi[Z_W-1] ? zi + ATAN : zi - ATAN;
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STAGES-1];
  assign x_out     = x[STAGES-1];
  assign y_out     = y[STAGES-1];
  assign tag_out   = tg[STAGES-1];

endmodule

FILE: src/armg_matrix.sv
// ----------------------------------------------------------------------------
// armg_matrix - output rounding and matrix assembly
// Rounds cosine and sine to the output format, clamps to +-1.0, maps them
// to the quadrant and places them in the rotation matrix for the axis.
// ----------------------------------------------------------------------------
module armg_matrix #(
  parameter int OUT_FRAC_BITS = armg_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [armg_pkg::XY_W-1:0] x_in,
  input  logic signed [armg_pkg::XY_W-1:0] y_in,
  input  armg_pkg::tag_t                   tag_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [armg_pkg::ELEM_W-1:0]      elem [armg_pkg::NUM_ELEM]
);
  import armg_pkg::*;

  localparam int SH    = Q_FRAC - OUT_FRAC_BITS;
  localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [XY_W-1:0] HALF = (SH > 0) ? (XY_W'(1) << SH_M1) : '0;
  localparam logic signed [XY_W-1:0] ONE  = XY_W'(1) << OUT_FRAC_BITS;

  // column-major element positions
  localparam int E00 = 0;
  localparam int E10 = 1;
  localparam int E20 = 2;
  localparam int E01 = 3;
  localparam int E11 = 4;
  localparam int E21 = 5;
  localparam int E02 = 6;
  localparam int E12 = 7;
  localparam int E22 = 8;

  function automatic logic signed [XY_W-1:0] to_out(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + HALF) >>> SH;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r;
  endfunction

  logic                   vld0, vld1;
  logic                   rdy0, rdy1;
  logic signed [XY_W-1:0] c0, s0;
  tag_t                   tg0;
  logic signed [XY_W-1:0] c, s;
  logic signed [XY_W-1:0] m [NUM_ELEM];

  assign rdy1 = !vld1 || out_ready;
  assign rdy0 = !vld0 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else begin
      if (rdy0) vld0 <= in_valid;
      if (rdy1) vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      c0  <= to_out(x_in);
      s0  <= to_out(y_in);
      tg0 <= tag_in;
    end
  end

  always_comb begin
    case (tg0.quad)
      QUAD_0:  begin c = c0;  s = s0;  end
      QUAD_1:  begin c = -s0; s = c0;  end
      QUAD_2:  begin c = -c0; s = -s0; end
      default: begin c = s0;  s = -c0; end
    endcase

    for (int k = 0; k < NUM_ELEM; k++) m[k] = '0;
    m[E00] = ONE;
    m[E11] = ONE;
    m[E22] = ONE;

    unique case (tg0.axis)
      AXIS_X: begin
        m[E11] = c;  m[E21] = -s; m[E12] = s;  m[E22] = c;
      end
      AXIS_Y: begin
        m[E00] = c;  m[E20] = s;  m[E02] = -s; m[E22] = c;
      end
      AXIS_Z: begin
        m[E00] = c;  m[E10] = -s; m[E01] = s;  m[E11] = c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1 && vld0) begin
      for (int k = 0; k < NUM_ELEM; k++) elem[k] <= m[k][ELEM_W-1:0];
    end
  end

  assign in_ready  = rdy0;
  assign out_valid = vld1;

  a_cos_clamped: assert property (@(posedge clk) disable iff (rst)
    vld0 |-> (c0 <= ONE) && (c0 >= -ONE))
    else $error("cosine outside clamp range");

  a_sin_clamped: assert property (@(posedge clk) disable iff (rst)
    vld0 |-> (s0 <= ONE) && (s0 >= -ONE))
    else $error("sine outside clamp range");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for axis_rotation_matrix_gen
// Drives angle/axis transfers with random gaps and checks each matrix
// against a behavioral model of the reduction, the CORDIC and the matrix
// build, or a typed-in matrix. A directed table of corner angles runs
// first, then 1200 random angles. The output side stalls at random and
// holds off once for long, so the pipeline fills and stops taking input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import armg_pkg::*;

  // Bench configuration
  localparam int STAGES       = CORDIC_STAGES_DEF;
  localparam int FRAC_OUT     = OUT_FRAC_BITS_DEF;
  localparam int NUM_DIRECTED = 22;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STEADY_FIRST = 500;    // first random item of the no-idle window
  localparam int STEADY_LAST  = 650;    // end of that window (exclusive)
  localparam int HOLD_AT      = 300;    // result count that triggers the long hold
  localparam int LONG_HOLD    = 150;    // cycles of out_ready low, well past the depth
  localparam int DRAIN_CYCLES = 64;     // quiet time after the last result
  localparam int IDLE_LIMIT   = 2000;   // cycles with no transfer before giving up
  localparam int MAX_REPORTS  = 10;

  // Angle units are 1/128 degree
  localparam longint FULL_TURN    = 46080;
  localparam longint QUARTER_TURN = 11520;

  localparam logic [AXIS_W-1:0] AXIS_UNUSED = 2'd3;

  typedef longint unsigned u64_t;

  // Nine Q2.14 entries, index = second * 3 + first (elem_0_0 at index 0)
  typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] mat_t;

  localparam logic [ELEM_W-1:0] ONE_Q = ELEM_W'(1 << FRAC_OUT);
  localparam logic [ELEM_W-1:0] ZERO_Q = '0;
  localparam mat_t IDENTITY = {ONE_Q, ZERO_Q, ZERO_Q, ZERO_Q, ONE_Q,
                               ZERO_Q, ZERO_Q, ZERO_Q, ONE_Q};

  typedef struct packed {
    logic signed [ANGLE_W-1:0] ang;
    logic [AXIS_W-1:0]         ax;
    mat_t                      m;
  } pending_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] ang;
    logic [AXIS_W-1:0]         ax;
    logic                      fixed;   // use the typed-in matrix below
    mat_t                      want;
  } plan_row_t;

  // Corner angles: zero, the field extremes, quadrant edges on both sides
  // and full-turn wrap. The unused axis code must give the identity.
  localparam plan_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{24'sd0,        AXIS_X,      1'b0, '0},
    '{24'sd0,        AXIS_Y,      1'b0, '0},
    '{24'sd0,        AXIS_Z,      1'b0, '0},
    '{24'sd8388607,  AXIS_X,      1'b0, '0},
    '{24'sh800000,   AXIS_Y,      1'b0, '0},
    '{-24'sd1,       AXIS_Z,      1'b0, '0},
    '{24'sd1,        AXIS_X,      1'b0, '0},
    '{24'sd5760,     AXIS_Y,      1'b0, '0},
    '{24'sd11519,    AXIS_Z,      1'b0, '0},
    '{24'sd11520,    AXIS_X,      1'b0, '0},
    '{24'sd11521,    AXIS_Y,      1'b0, '0},
    '{24'sd23040,    AXIS_Z,      1'b0, '0},
    '{24'sd34560,    AXIS_X,      1'b0, '0},
    '{24'sd46079,    AXIS_Y,      1'b0, '0},
    '{24'sd46080,    AXIS_Z,      1'b0, '0},
    '{-24'sd11520,   AXIS_X,      1'b0, '0},
    '{-24'sd23040,   AXIS_Y,      1'b0, '0},
    '{-24'sd46081,   AXIS_Z,      1'b0, '0},
    '{24'sd3840,     AXIS_Z,      1'b0, '0},
    '{24'sd7680,     AXIS_X,      1'b0, '0},
    '{24'sd12345,    AXIS_UNUSED, 1'b1, IDENTITY},
    '{24'sh800000,   AXIS_UNUSED, 1'b1, IDENTITY}
  };

  // DUT ports; every input starts at a known value
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] angle_deg = '0;
  logic        [AXIS_W-1:0]  axis = AXIS_X;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ELEM_W-1:0]  elem_0_0, elem_1_0, elem_2_0;
  logic signed [ELEM_W-1:0]  elem_0_1, elem_1_1, elem_2_1;
  logic signed [ELEM_W-1:0]  elem_0_2, elem_1_2, elem_2_2;

  // Bench state
  pending_t pending_matrices [$];
  bit       steady = 1'b0;      // both sides run without idling while set
  int       mismatches = 0;
  int       results_seen = 0;
  int       random_sent = 0;
  int       idle_cycles = 0;

  axis_rotation_matrix_gen DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .angle_deg (angle_deg),
    .axis      (axis),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .elem_0_0  (elem_0_0),
    .elem_1_0  (elem_1_0),
    .elem_2_0  (elem_2_0),
    .elem_0_1  (elem_0_1),
    .elem_1_1  (elem_1_1),
    .elem_2_1  (elem_2_1),
    .elem_0_2  (elem_0_2),
    .elem_1_2  (elem_1_2),
    .elem_2_2  (elem_2_2)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------

  // Round half up from Q30 to the output fraction, then clamp to +-1.0.
  function automatic longint round_q30(longint v);
    longint r;
    longint one;
    one = longint'(1) << FRAC_OUT;
    r = v;
    if (FRAC_OUT < 30)
      r = (v + (longint'(1) << (29 - FRAC_OUT))) >>> (30 - FRAC_OUT);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r;
  endfunction

  function automatic mat_t predict_rotation(logic signed [ANGLE_W-1:0] ang,
                                            logic [AXIS_W-1:0] ax);
    longint a, r, f, x, y, z, dx, dy, c0, s0, c, s;
    longint m [3][3];
    logic [QUAD_W-1:0] quad;
    mat_t res;
    // Reduce to [0, 360) degrees, split off the quadrant
    a = ang;
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    quad = QUAD_W'(r / QUARTER_TURN);
    f = r - (r / QUARTER_TURN) * QUARTER_TURN;
    // Remainder to Q2.30 radians
    z = longint'((u64_t'(f) * RAD_SCALE + (u64_t'(1) << (RAD_SHIFT - 1))) >> RAD_SHIFT);
    // Rotation-mode CORDIC, floor shifts
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_Q30[i]);
      end
    end
    c0 = round_q30(x);
    s0 = round_q30(y);
    case (quad)
      QUAD_0: begin c = c0;  s = s0;  end
      QUAD_1: begin c = -s0; s = c0;  end
      QUAD_2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
    for (int fi = 0; fi < 3; fi++)
      for (int se = 0; se < 3; se++)
        m[fi][se] = (fi == se) ? (longint'(1) << FRAC_OUT) : 0;
    case (ax)
      AXIS_X: begin m[1][1] = c; m[2][1] = -s; m[1][2] = s; m[2][2] = c; end
      AXIS_Y: begin m[0][0] = c; m[2][0] = s; m[0][2] = -s; m[2][2] = c; end
      AXIS_Z: begin m[0][0] = c; m[1][0] = -s; m[0][1] = s; m[1][1] = c; end
      default: ;  // unused code keeps the identity
    endcase
    for (int se = 0; se < 3; se++)
      for (int fi = 0; fi < 3; fi++)
        res[se * 3 + fi] = ELEM_W'(m[fi][se]);
    return res;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Enter and leave at a falling edge. Drop valid for a random gap, present
  // the item, hold it until the transfer and record the expected matrix.
  task automatic offer(input logic signed [ANGLE_W-1:0] ang,
                       input logic [AXIS_W-1:0] ax, input mat_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    angle_deg <= ang;
    axis      <= ax;
    do @(posedge clk); while (!in_ready);
    pending_matrices.push_back('{ang, ax, want});
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic signed [ANGLE_W-1:0] ang;
    logic [AXIS_W-1:0] ax;
    int sel;
    int turns;
    // Hold reset, release at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: typed-in matrix where given, model otherwise
    for (int i = 0; i < NUM_DIRECTED; i++)
      offer(DIRECTED_ROWS[i].ang, DIRECTED_ROWS[i].ax,
            DIRECTED_ROWS[i].fixed ? DIRECTED_ROWS[i].want
                                   : predict_rotation(DIRECTED_ROWS[i].ang,
                                                      DIRECTED_ROWS[i].ax));

    // Random angles: half over the whole field, a quarter within a few
    // units of a quadrant edge, a quarter within one turn of zero
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= STEADY_FIRST && n < STEADY_LAST);
      sel = $urandom_range(0, 3);
      case (sel)
        0, 1: ang = ANGLE_W'($urandom);
        2: begin
          turns = int'($urandom_range(0, 1456)) - 728;
          ang = ANGLE_W'(turns * QUARTER_TURN + int'($urandom_range(0, 6)) - 3);
        end
        default: ang = ANGLE_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
      endcase
      ax = AXIS_W'($urandom_range(0, 2));
      offer(ang, ax, predict_rotation(ang, ax));
      random_sent++;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Drain: wait for every pending matrix, then let stray results show up
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random angles on all axes and the unused code,",
             NUM_DIRECTED, random_sent);
    $display("with one long output hold; %0d matrices checked, %0d field errors",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold, compare on every transfer
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall_left;
    mat_t got;
    pending_t want;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {elem_2_2, elem_1_2, elem_0_2, elem_2_1, elem_1_1, elem_0_1,
               elem_2_0, elem_1_0, elem_0_0};
        if (pending_matrices.size() == 0) begin
          note_failure($sformatf("matrix %h with no request outstanding", got));
        end else begin
          want = pending_matrices.pop_front();
          for (int k = 0; k < NUM_ELEM; k++)
            if (got[k] !== want.m[k])
              note_failure($sformatf("angle %0d axis %0d elem_%0d_%0d: exp %0d got %0d",
                                     want.ang, want.ax, k % 3, k / 3,
                                     $signed(want.m[k]), $signed(got[k])));
        end
        results_seen++;
        // Hold off long enough once to back the pipeline up to the input
        if (results_seen == HOLD_AT)
          stall_left = LONG_HOLD;
        else
          stall_left = steady ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer, %0d matrices pending",
               IDLE_LIMIT, pending_matrices.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
